[design/sum_limited_fifo_top_defines.svh]
// Assertion macros for the sum-limited queue, used by the queue controller (slf_ctrl).
`ifndef SUM_LIMITED_FIFO_TOP_DEFINES_SVH
`define SUM_LIMITED_FIFO_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define SLF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SLF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SLF_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define SLF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[design/slf_pkg.sv]
// Types and constants of the sum-limited queue.
`timescale 1ns / 1ps
`default_nettype none

package slf_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VALUE_W     = 16;
    localparam int SUM_W       = 23;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [SUM_W-1:0]   t_sum;

    localparam t_sum LIMIT_RESET = t_sum'(50);
    localparam t_cnt COUNT_FULL  = t_cnt'(QUEUE_DEPTH);

    // Request codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result codes
    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_OVER_LIMIT = 3'd1,
        ST_FULL       = 3'd2,
        ST_DEQUEUED   = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    // Control from the queue controller to every cell of the chain
    typedef struct packed {
        logic   shift;
        logic   load;
        t_idx   load_slot;
        t_value load_value;
    } t_chain_ctl;

endpackage

`default_nettype wire

[design/slf_cell.sv]
// One storage cell of the queue chain: holds one item, shifts toward the head.
`timescale 1ns / 1ps
`default_nettype none

module slf_cell (
    input  wire                 i_clk,
    input  slf_pkg::t_chain_ctl i_ctl,
    input  slf_pkg::t_idx       i_slot,
    input  slf_pkg::t_value     i_up_data,
    output slf_pkg::t_value     o_data
);
    import slf_pkg::*;

    t_value r_data;
    t_value n_data;

    // Take the neighbour's item on a dequeue, the new item when this slot is the tail
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_up_data;
        end else if (i_ctl.load && (i_ctl.load_slot == i_slot)) begin
            n_data = i_ctl.load_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[design/slf_ctrl.sv]
// Queue controller: admission check, entry count, running total and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "sum_limited_fifo_top_defines.svh"

module slf_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_operation,
    input  slf_pkg::t_value     i_value,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output slf_pkg::t_status    o_status,
    output slf_pkg::t_value     o_removed_value,
    output slf_pkg::t_sum       o_current_sum,
    input  wire                 i_cfg_valid,
    input  slf_pkg::t_sum       i_cfg_sum_limit,
    input  slf_pkg::t_value     i_head_data,
    output slf_pkg::t_chain_ctl o_ctl
);
    import slf_pkg::*;

    t_cnt    r_count;
    t_cnt    n_count;
    t_sum    r_total;
    t_sum    n_total;
    t_sum    r_limit;
    logic    r_out_valid;
    t_status r_status;
    t_status n_status;
    t_value  r_removed;
    t_value  n_removed;
    t_sum    r_sum;

    logic            accept;
    logic [SUM_W:0]  sum_ext;
    logic            over_limit;
    logic            full;
    logic            empty;

    // Hold new items while a result waits downstream
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign sum_ext    = {1'b0, r_total} + {{(SUM_W + 1 - VALUE_W){1'b0}}, i_value};
    assign over_limit = sum_ext > {1'b0, r_limit};
    assign full       = (r_count == COUNT_FULL);
    assign empty      = (r_count == '0);

    // Decide the request: limit first, then room; dequeue pops the head cell
    always_comb begin
        n_count          = r_count;
        n_total          = r_total;
        n_removed        = '0;
        o_ctl.shift      = 1'b0;
        o_ctl.load       = 1'b0;
        o_ctl.load_slot  = r_count[IDX_W-1:0];
        o_ctl.load_value = i_value;
        if (i_operation == OP_DEQ) begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status    = ST_DEQUEUED;
                n_removed   = i_head_data;
                n_count     = r_count - t_cnt'(1);
                n_total     = r_total - t_sum'(i_head_data);
                o_ctl.shift = accept;
            end
        end else begin
            if (over_limit) begin
                n_status = ST_OVER_LIMIT;
            end else if (full) begin
                n_status = ST_FULL;
            end else begin
                n_status   = ST_INSERTED;
                n_count    = r_count + t_cnt'(1);
                n_total    = sum_ext[SUM_W-1:0];
                o_ctl.load = accept;
            end
        end
    end

    // Advance queue state on an accepted item; take limit writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_total <= n_total;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_sum_limit;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_sum     <= n_total;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_current_sum   = r_sum;

    `SLF_ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= COUNT_FULL,
                    "entry count above depth")
    `SLF_ASSERT_CLK(a_empty_total, i_clk, i_rst_n,
                    (r_count == '0) |-> (r_total == '0),
                    "empty queue with nonzero total")
    `SLF_ASSERT_CLK(a_insert_count, i_clk, i_rst_n,
                    o_ctl.load |=> (r_count == $past(r_count) + t_cnt'(1)),
                    "insert did not grow count")
    `SLF_ASSERT_CLK(a_pop_total, i_clk, i_rst_n,
                    o_ctl.shift |=> (r_total == $past(r_total) - t_sum'($past(i_head_data))),
                    "pop did not reduce total by head item")
    `SLF_ASSERT_CLK(a_removed_zero, i_clk, i_rst_n,
                    (r_out_valid && (r_status != ST_DEQUEUED)) |-> (r_removed == '0),
                    "removed value set without a dequeue")

endmodule

`default_nettype wire

[design/sum_limited_fifo_top.sv]
// Top level of the sum-limited queue: controller plus a chain of storage cells.
//
//  Channel   Direction  Handshake                 Payload
//  request   in         i_in_valid / o_in_stall   i_operation, i_value
//  result    out        o_out_valid / i_out_stall o_status, o_removed_value, o_current_sum
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_sum_limit
//
// One request per clock while the result side is not stalled; its result is registered in the next cycle.
// The head of the queue is always cell 0, so a dequeue reads a fixed place and the
// whole chain shifts one cell toward the head in the same cycle.
// Reset (synchronous, active low) clears count, total and the result valid and loads
// the limit with 50; cell contents are left as they are.
// A stalled result holds the request side off only while it stays unread.
`timescale 1ns / 1ps
`default_nettype none

module sum_limited_fifo_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire                     i_operation,
    input  wire  [15:0]             i_value,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output logic [2:0]              o_status,
    output logic [15:0]             o_removed_value,
    output logic [22:0]             o_current_sum,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [22:0]             i_cfg_sum_limit
);
    import slf_pkg::*;

    t_chain_ctl ctl;
    t_status    status;
    t_value     cell_data [QUEUE_DEPTH];

    // Limit writes are taken in any cycle
    assign o_cfg_ready = 1'b1;

    slf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (status),
        .o_removed_value (o_removed_value),
        .o_current_sum   (o_current_sum),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_sum_limit (i_cfg_sum_limit),
        .i_head_data     (cell_data[0]),
        .o_ctl           (ctl)
    );

    assign o_status = status;

    // Build the chain: each cell takes its upper neighbour's item on a dequeue
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_value up_data;
        if (k == QUEUE_DEPTH - 1) begin : g_last
            assign up_data = '0;
        end else begin : g_mid
            assign up_data = cell_data[k+1];
        end
        slf_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_slot    (t_idx'(k)),
            .i_up_data (up_data),
            .o_data    (cell_data[k])
        );
    end

endmodule

`default_nettype wire

[tb/sv/tb_sum_limited_fifo_top.sv]
// Testbench for the sum-limited queue: a mirrored queue and total check every result.
`timescale 1ns / 1ps

module tb_sum_limited_fifo_top;

    import slf_pkg::*;

    localparam t_sum SUM_MAX     = '1;
    localparam int   CYCLE_LIMIT = 500000;
    localparam int   REPORT_MAX  = 10;
    localparam int   PHASES      = 10;

    typedef struct {
        t_status status;
        t_value  removed;
        t_sum    total;
    } t_fifo_result;

    // Mirror of the queue: holds the values, their total and the limit,
    // and lines up the result that each request should give.
    class admission_checker;
        t_value       held_values[$];
        t_sum         held_total;
        t_sum         sum_cap;
        t_fifo_result pending_results[$];
        int           mismatches;
        int           status_seen[5];
        int           peak_fill;

        function new();
            held_total = '0;
            sum_cap    = LIMIT_RESET;
            mismatches = 0;
            peak_fill  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_cap(t_sum cap);
            sum_cap = cap;
        endfunction

        // Work out the result of one accepted request and advance the mirror
        function void take_request(logic op, t_value val);
            t_fifo_result r;
            int unsigned  trial;
            r.removed = '0;
            if (op == OP_ENQ) begin
                trial = 32'(held_total) + 32'(val);
                if (trial > 32'(sum_cap)) begin
                    r.status = ST_OVER_LIMIT;
                end else if (held_values.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_values.push_back(val);
                    held_total = t_sum'(trial);
                    r.status   = ST_INSERTED;
                    if (held_values.size() > peak_fill) peak_fill = held_values.size();
                end
            end else if (held_values.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed  = held_values.pop_front();
                held_total = held_total - t_sum'(r.removed);
                r.status   = ST_DEQUEUED;
            end
            r.total = held_total;
            pending_results.push_back(r);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, what);
        endfunction

        // Compare one result from the block with the oldest expectation
        function void check_result(logic [2:0] st, t_value rv, t_sum tot);
            t_fifo_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing pending: status %0d removed %0d sum %0d",
                                 st, rv, tot));
                return;
            end
            want = pending_results.pop_front();
            status_seen[want.status]++;
            if (st !== want.status || rv !== want.removed || tot !== want.total)
                report($sformatf({"result mismatch: expected status %0d removed %0d sum %0d,",
                                  " got status %0d removed %0d sum %0d"},
                                 want.status, want.removed, want.total, st, rv, tot));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_operation;
    logic [15:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [15:0] o_removed_value;
    logic [22:0] o_current_sum;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [22:0] i_cfg_sum_limit;

    admission_checker sb = new();
    bit  tx_idle_on = 1'b0;
    bit  rx_idle_on = 1'b0;
    int  requests_sent = 0;
    int  limit_writes = 0;
    int  cycle_count = 0;

    sum_limited_fifo_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_current_sum   (o_current_sum),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_sum_limit (i_cfg_sum_limit)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Check every result taken from the output
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_removed_value, o_current_sum);
    end

    // Hold the result side off in short random bursts
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(logic op, t_value val);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_request(op, val);
        requests_sent++;
    endtask

    // Stop sending and wait until every expected result is in
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the limit register; only called with the block idle
    task automatic write_limit(t_sum cap);
        i_cfg_valid     <= 1'b1;
        i_cfg_sum_limit <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_cap(cap);
        limit_writes++;
    endtask

    // Mostly values scaled to the limit, some full range and some extremes
    function automatic t_value pick_value(t_sum cap);
        int unsigned scale;
        scale = cap / 8;
        if (scale < 1) scale = 1;
        if (scale > 65535) scale = 65535;
        case ($urandom_range(0, 19))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return t_value'($urandom);
            default:    return t_value'($urandom_range(0, scale));
        endcase
    endfunction

    initial begin
        int   items;
        int   enq_pct;
        t_sum cap;

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_operation     <= OP_ENQ;
        i_value         <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_sum_limit <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue, zero value, total exactly at the reset limit
        send_request(OP_DEQ, '1);
        send_request(OP_ENQ, '0);
        send_request(OP_ENQ, 16'd50);
        send_request(OP_ENQ, 16'd1);
        send_request(OP_ENQ, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_ENQ, '1);
        send_request(OP_ENQ, 16'd30);
        drain_results();

        // Directed: limit lowered below the held total
        write_limit(t_sum'(10));
        send_request(OP_ENQ, '0);
        send_request(OP_ENQ, '1);
        send_request(OP_DEQ, '0);
        send_request(OP_ENQ, '0);
        send_request(OP_ENQ, 16'd10);
        send_request(OP_ENQ, 16'd1);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        send_request(OP_DEQ, '0);
        drain_results();

        // Random phases, each with its own limit and mix; the last ones without idling
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 6)
                0, 5:    cap = SUM_MAX;
                1:       cap = t_sum'($urandom_range(0, 300));
                2:       cap = '0;
                3:       cap = t_sum'($urandom_range(0, SUM_MAX));
                default: cap = t_sum'($urandom_range(1000, 200000));
            endcase
            case (ph % 4)
                0:       enq_pct = 95;
                1:       enq_pct = 50;
                2:       enq_pct = 30;
                default: enq_pct = 80;
            endcase
            items      = (ph % 4 == 0) ? 200 : 100;
            tx_idle_on = (ph < PHASES - 2) && ($urandom_range(0, 4) != 0);
            rx_idle_on = (ph < PHASES - 2) && ($urandom_range(0, 4) != 0);
            write_limit(cap);
            for (int n = 0; n < items; n++) begin
                if ($urandom_range(1, 100) <= enq_pct)
                    send_request(OP_ENQ, pick_value(cap));
                else
                    send_request(OP_DEQ, t_value'($urandom));
            end
            drain_results();
        end

        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests under %0d limit settings, peak fill %0d of %0d.",
                 requests_sent, limit_writes + 1, sb.peak_fill, QUEUE_DEPTH);
        $display("Seen: %0d inserted, %0d over limit, %0d full, %0d dequeued, %0d empty.",
                 sb.status_seen[ST_INSERTED], sb.status_seen[ST_OVER_LIMIT],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_DEQUEUED],
                 sb.status_seen[ST_EMPTY]);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     sb.mismatches, sb.pending_results.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/slf_pkg.sv
design/slf_cell.sv
design/slf_ctrl.sv
design/sum_limited_fifo_top.sv
tb/sv/tb_sum_limited_fifo_top.sv
